FILE: src/fpd_pkg.sv
package fpd_pkg;

    // default frame length in bytes, header included
    localparam int FRAME_BYTES_DEF = 32;

    // frame layout: header length, checksum and tail offsets from frame end
    localparam int HDR_BYTES   = 4;
    localparam int CSUM_OFFSET = 8;
    localparam int TAIL_OFFSET = 4;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int WINDOW_W = 24;
    localparam int STATUS_W = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd1;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CSUM = 2'd2;

endpackage

FILE: src/framed_packet_deframer_checksum_top.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_rx_byte
// output   | o_out_valid  | i_out_stall  | o_frame_status, o_good_frames, o_bad_frames,
//          |              |              | o_computed_sum, o_received_sum
// config   | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while o_in_stall is low; a byte is registered, then processed
// from the input register, and a frame result is registered in the result register when its last byte is taken
// the per-byte path is one 32-bit add for the running sum and 32-bit compares (header, tail, sum)
// o_in_stall rises only when the last byte of a frame waits on a stalled, full output
// i_rst_n is synchronous, active low: unsynced, counters, configuration and valid flags cleared

module framed_packet_deframer_checksum_top #(
    parameter int FRAME_BYTES = fpd_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fpd_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fpd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fpd_pkg::STATUS_W-1:0]  o_frame_status,
    output logic [fpd_pkg::WORD_W-1:0]    o_good_frames,
    output logic [fpd_pkg::WORD_W-1:0]    o_bad_frames,
    output logic [fpd_pkg::WORD_W-1:0]    o_computed_sum,
    output logic [fpd_pkg::WORD_W-1:0]    o_received_sum
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_START = POS_W'(fpd_pkg::HDR_BYTES);
    localparam logic [POS_W-1:0] POS_CSUM  = POS_W'(FRAME_BYTES - fpd_pkg::CSUM_OFFSET);
    localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(FRAME_BYTES - fpd_pkg::TAIL_OFFSET);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END   = POS_W'(FRAME_BYTES);

    localparam int W = fpd_pkg::WORD_W;
    localparam int B = fpd_pkg::BYTE_W;

    // configuration
    logic [W-1:0] r_header_word;
    logic [W-1:0] r_tail_word;

    // input register
    logic         r_in_valid;
    logic [B-1:0] r_in_byte;

    // frame state
    logic                        r_synced,  n_synced;
    logic [fpd_pkg::WINDOW_W-1:0] r_window, n_window;
    logic [POS_W-1:0]            r_pos,     n_pos;
    logic [W-1:0]                r_sum,     n_sum;
    logic [W-1:0]                r_csum,    n_csum;
    logic [W-1:0]                r_tail,    n_tail;
    logic [W-1:0]                r_good,    n_good;
    logic [W-1:0]                r_bad,     n_bad;
    logic [fpd_pkg::STATUS_W-1:0] n_status;
    logic                        n_emit;

    // result register
    logic                         r_out_valid;
    logic [fpd_pkg::STATUS_W-1:0] r_out_status;
    logic [W-1:0]                 r_out_good;
    logic [W-1:0]                 r_out_bad;
    logic [W-1:0]                 r_out_sum;
    logic [W-1:0]                 r_out_csum;

    logic         w_hold;
    logic         w_take;
    logic         w_accept;
    logic [1:0]   w_lane_csum;
    logic [1:0]   w_lane_tail;
    logic [W-1:0] w_word;

    // last byte of a frame cannot proceed while the result register is blocked
    assign w_hold   = r_in_valid && r_synced && (r_pos == POS_LAST)
                      && r_out_valid && i_out_stall;
    assign w_take   = r_in_valid && !w_hold;
    assign o_in_stall = w_hold;
    assign w_accept = i_in_valid && !o_in_stall;

    assign w_word      = {r_in_byte, r_window};
    assign w_lane_csum = 2'(r_pos - POS_CSUM);
    assign w_lane_tail = 2'(r_pos - POS_TAIL);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_word <= '0;
            r_tail_word   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpd_pkg::CFG_HEADER: r_header_word <= i_cfg_data;
                fpd_pkg::CFG_TAIL:   r_tail_word   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // per-byte frame logic
    always_comb begin
        n_synced = r_synced;
        n_window = r_window;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_csum   = r_csum;
        n_tail   = r_tail;
        n_good   = r_good;
        n_bad    = r_bad;
        n_status = fpd_pkg::ST_OK;
        n_emit   = 1'b0;
        if (!r_synced) begin
            // header search over a sliding four-byte window
            if (w_word == r_header_word) begin
                n_synced = 1'b1;
                n_pos    = POS_START;
                n_sum    = '0;
                n_csum   = '0;
                n_tail   = '0;
            end else begin
                n_window = w_word[W-1:B];
            end
        end else begin
            if (r_pos < POS_CSUM) begin
                n_sum = r_sum + W'(r_in_byte);
            end else if (r_pos < POS_TAIL) begin
                for (int j = 0; j < 4; j++) begin
                    if (w_lane_csum == 2'(j)) begin
                        n_csum[j*B +: B] = r_in_byte;
                    end
                end
            end else begin
                for (int j = 0; j < 4; j++) begin
                    if (w_lane_tail == 2'(j)) begin
                        n_tail[j*B +: B] = r_in_byte;
                    end
                end
            end
            n_pos = r_pos + 1'b1;
            // frame end: tail checked before checksum
            if (n_pos == POS_END) begin
                n_emit = 1'b1;
                if (n_tail != r_tail_word) begin
                    n_status = fpd_pkg::ST_BAD_TAIL;
                    n_bad    = r_bad + 1'b1;
                end else if (n_sum != n_csum) begin
                    n_status = fpd_pkg::ST_BAD_CSUM;
                    n_bad    = r_bad + 1'b1;
                end else begin
                    n_good   = r_good + 1'b1;
                end
            end
        end
    end

    // frame state update; per-frame state cleared after each frame, frame counters kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0;
            r_window <= '0;
            r_pos    <= '0;
            r_sum    <= '0;
            r_csum   <= '0;
            r_tail   <= '0;
            r_good   <= '0;
            r_bad    <= '0;
        end else if (w_take) begin
            r_good <= n_good;
            r_bad  <= n_bad;
            if (n_emit) begin
                r_synced <= 1'b0;
                r_window <= '0;
                r_pos    <= '0;
                r_sum    <= '0;
                r_csum   <= '0;
                r_tail   <= '0;
            end else begin
                r_synced <= n_synced;
                r_window <= n_window;
                r_pos    <= n_pos;
                r_sum    <= n_sum;
                r_csum   <= n_csum;
                r_tail   <= n_tail;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take && n_emit) begin
            r_out_status <= n_status;
            r_out_good   <= n_good;
            r_out_bad    <= n_bad;
            r_out_sum    <= n_sum;
            r_out_csum   <= n_csum;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_out_status;
    assign o_good_frames  = r_out_good;
    assign o_bad_frames   = r_out_bad;
    assign o_computed_sum = r_out_sum;
    assign o_received_sum = r_out_csum;

`ifndef SYNTHESIS
    // position stays inside the frame while synced
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_synced |-> (r_pos >= POS_START && r_pos < POS_END))
        else $error("byte position outside frame while synced");

    // unsynced state holds no frame progress
    a_unsynced_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_synced |-> (r_pos == '0 && r_sum == '0))
        else $error("frame state not cleared while unsynced");

    // a completed frame shows a result next cycle and drops sync
    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && n_emit) |=> (r_out_valid && !r_synced))
        else $error("frame end without result or resync");

    // input stall only when a result is blocked downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a blocked result");

    // a status code other than the three defined never appears
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == fpd_pkg::ST_OK
                         || r_out_status == fpd_pkg::ST_BAD_TAIL
                         || r_out_status == fpd_pkg::ST_BAD_CSUM))
        else $error("undefined frame status");
`endif

endmodule
